// File: rtl/rtcs_pkg.sv
// Shared types, sizing constants and helpers for the tanh recurrent cell step unit.
// Used by every module in rtl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rtcs_pkg;

    localparam int HIDDEN_UNITS  = 128;
    localparam int INPUT_SYMBOLS = 256;
    localparam int WEIGHT_BITS   = 16;

    localparam int ROW_W  = $clog2(HIDDEN_UNITS);
    localparam int SYM_W  = $clog2(INPUT_SYMBOLS);
    localparam int HID_W  = 16;   // Q1.14 hidden value
    localparam int ACC_W  = 32;   // Q5.26 accumulator
    localparam int HID_FRAC = 14;

    // weight saturation to WEIGHT_BITS signed bits
    localparam int WX_W = ((WEIGHT_BITS > 16) ? WEIGHT_BITS : 16) + 1;
    localparam logic signed [WX_W-1:0] W_HI = WX_W'((64'sd1 <<< (WEIGHT_BITS - 1)) - 64'sd1);
    localparam logic signed [WX_W-1:0] W_LO = WX_W'(-(64'sd1 <<< (WEIGHT_BITS - 1)));

    typedef logic [2:0] t_op;
    localparam t_op OP_WR_IN   = 3'd0;
    localparam t_op OP_WR_REC  = 3'd1;
    localparam t_op OP_WR_BIAS = 3'd2;
    localparam t_op OP_STEP    = 3'd3;
    localparam t_op OP_RD_HID  = 3'd4;
    localparam t_op OP_CLR     = 3'd5;

    typedef struct packed {
        t_op                op;
        logic [7:0]         symbol;
        logic [6:0]         row_index;
        logic [6:0]         col_index;
        logic signed [15:0] weight_value;
    } t_req;

    typedef struct packed {
        logic signed [15:0] hidden_value;
        t_op                done_op;
    } t_rsp;

    typedef struct packed {
        logic init;    // load accumulator with (bias + input weight) << 14
        logic valid;   // weight/hidden pair present at MAC input
    } t_mac_ctl;

    function automatic logic signed [WEIGHT_BITS-1:0] f_sat_weight(
        input logic signed [15:0] v
    );
        logic signed [WX_W-1:0] ext;
        ext = WX_W'(v);
        if (ext > W_HI) begin
            ext = W_HI;
        end else if (ext < W_LO) begin
            ext = W_LO;
        end
        return WEIGHT_BITS'(ext);
    endfunction

endpackage

`default_nettype wire

// File: rtl/rtcs_mac.sv
// Shared multiply-accumulate unit: registered product, 32-bit saturating accumulator.
// Depends on rtcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtcs_mac
    import rtcs_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_mac_ctl                      i_ctl,
    input  logic signed [WEIGHT_BITS-1:0] i_bias,
    input  logic signed [WEIGHT_BITS-1:0] i_iw,
    input  logic signed [WEIGHT_BITS-1:0] i_w,
    input  logic signed [HID_W-1:0]       i_h,
    output logic signed [ACC_W-1:0]       o_acc,
    output logic                          o_idle
);

    localparam int PROD_W = WEIGHT_BITS + HID_W;
    localparam int SUM_W  = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam longint AccMaxL = 64'sd2147483647;
    localparam longint AccMinL = -64'sd2147483648;
    localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(AccMaxL);
    localparam logic signed [SUM_W-1:0] SUM_LO = SUM_W'(AccMinL);

    logic                        r_p_v;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [WEIGHT_BITS:0] start;
    logic signed [SUM_W-1:0]     init_ext;
    logic signed [SUM_W-1:0]     sum_ext;

    function automatic logic signed [ACC_W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (c > SUM_HI) begin
            c = SUM_HI;
        end else if (c < SUM_LO) begin
            c = SUM_LO;
        end
        return ACC_W'(c);
    endfunction

    assign start    = (WEIGHT_BITS + 1)'(i_bias) + (WEIGHT_BITS + 1)'(i_iw);
    assign init_ext = SUM_W'(start) <<< HID_FRAC;
    assign sum_ext  = SUM_W'(r_acc) + SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else begin
            r_p_v <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_w * i_h;
        if (i_ctl.init) begin
            r_acc <= f_sat(init_ext);
        end else if (r_p_v) begin
            r_acc <= f_sat(sum_ext);
        end
    end

    assign o_acc  = r_acc;
    assign o_idle = !r_p_v;

endmodule

`default_nettype wire

// File: rtl/rtcs_tanh.sv
// Three-stage piecewise-linear tanh over quarter steps, Q5.26 in, Q1.14 out.
// Depends on rtcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rtcs_tanh
    import rtcs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic                    o_done,
    output logic signed [HID_W-1:0] o_y
);

    localparam logic [ACC_W-1:0] TANH_SAT = ACC_W'(5) << 26;  // 5.0 in Q5.26

    function automatic logic [14:0] f_tab(input logic [4:0] k);
        logic [14:0] t;
        case (k)
            5'd0:    t = 15'd0;
            5'd1:    t = 15'd4013;
            5'd2:    t = 15'd7571;
            5'd3:    t = 15'd10406;
            5'd4:    t = 15'd12478;
            5'd5:    t = 15'd13898;
            5'd6:    t = 15'd14830;
            5'd7:    t = 15'd15423;
            5'd8:    t = 15'd15795;
            5'd9:    t = 15'd16024;
            5'd10:   t = 15'd16165;
            5'd11:   t = 15'd16250;
            5'd12:   t = 15'd16303;
            5'd13:   t = 15'd16335;
            5'd14:   t = 15'd16354;
            5'd15:   t = 15'd16366;
            5'd16:   t = 15'd16373;
            5'd17:   t = 15'd16377;
            5'd18:   t = 15'd16380;
            5'd19:   t = 15'd16382;
            default: t = 15'd16383;
        endcase
        return t;
    endfunction

    logic             r_v1, r_v2, r_v3;
    logic             r_neg1, r_neg2, r_big1, r_big2;
    logic [4:0]       r_k;
    logic [23:0]      r_f;
    logic [14:0]      r_t0;
    logic [38:0]      r_prod;
    logic signed [HID_W-1:0] r_y;

    logic [ACC_W-1:0] mag;
    logic [4:0]       k_safe;
    logic [14:0]      t0, t1, d;
    logic [39:0]      rnd;
    logic [14:0]      y;

    assign mag    = i_acc[ACC_W-1] ? (~i_acc + 1'b1) : i_acc;
    assign k_safe = r_big1 ? 5'd0 : r_k;
    assign t0     = f_tab(k_safe);
    assign t1     = f_tab(k_safe + 5'd1);
    assign d      = t1 - t0;
    assign rnd    = 40'(r_prod) + 40'h80_0000;
    assign y      = r_big2 ? 15'd16384 : (r_t0 + rnd[38:24]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        // stage 1: magnitude, segment, fraction
        r_neg1 <= i_acc[ACC_W-1];
        r_big1 <= (mag >= TANH_SAT);
        r_k    <= mag[28:24];
        r_f    <= mag[23:0];
        // stage 2: table and slope product
        r_neg2 <= r_neg1;
        r_big2 <= r_big1;
        r_t0   <= t0;
        r_prod <= 39'(d) * 39'(r_f);
        // stage 3: round, add, restore sign
        r_y    <= r_neg2 ? -$signed({1'b0, y}) : $signed({1'b0, y});
    end

    assign o_done = r_v3;
    assign o_y    = r_y;

endmodule

`default_nettype wire

// File: rtl/rnn_tanh_cell_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Elman recurrent cell with tanh, fed one byte symbol per step request.
// Depends on rtcs_pkg, rtcs_mac and rtcs_tanh.
//
// Input channel (i_in_valid / o_in_stall / i_in_req) takes one request: write
// input weight, write recurrent weight, write bias, step, read hidden unit, or
// clear hidden vector. Output channel (o_out_valid / i_out_stall / o_out_rsp)
// returns exactly one response per request: hidden_value (read only, else zero)
// and the echoed op.
// Writes, clear and unknown ops load their response at acceptance, so it is valid
// in the next cycle; a hidden read passes through S_FIN before its response loads.
// A step runs one shared multiply-accumulate per cycle in S_MAC: per hidden unit it
// fetches bias and input weight (S_LOAD), initialises the accumulator (S_INIT), runs
// the MAC loop over the row's recurrent weights (S_MAC), drains the MAC pipeline
// (S_DRAIN) and waits for the 3-stage tanh (S_TANH).
// One request at a time: o_in_stall stays high while a request is in flight or
// while an undelivered response blocks the output register, where a stalled
// response holds.
// The hidden vector is double-banked: a step writes the other bank and swaps
// banks at its end. Reset clears control state and the hidden valid bits, so
// the vector reads as zero; weights and biases stay undefined until written.

module rnn_tanh_cell_step_unit
    import rtcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    localparam int IW_D = HIDDEN_UNITS << SYM_W;
    localparam int RW_D = HIDDEN_UNITS << ROW_W;
    localparam int HB_D = 2 << ROW_W;
    localparam logic [ROW_W-1:0] I_LAST = ROW_W'(HIDDEN_UNITS - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_INIT  = 7'b0000100,
        S_MAC   = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_TANH  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    // storage
    logic signed [WEIGHT_BITS-1:0] iw_mem   [IW_D];
    logic signed [WEIGHT_BITS-1:0] rw_mem   [RW_D];
    logic signed [WEIGHT_BITS-1:0] bias_mem [HIDDEN_UNITS];
    logic signed [HID_W-1:0]       hid_mem  [HB_D];
    logic [HB_D-1:0]               r_hv_valid;

    // control
    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_i, r_j;
    logic [SYM_W-1:0] r_sym;
    logic             r_sym_ok, r_row_ok;
    t_op              r_op;
    logic             r_bank;
    logic             r_rd_v;
    logic             r_out_v;
    t_rsp             r_out;

    // read data
    logic signed [WEIGHT_BITS-1:0] r_iw_q, r_rw_q, r_bias_q;
    logic signed [HID_W-1:0]       r_hrd;
    logic                          r_hrd_v;

    // request decode
    logic                          in_acc, out_free, out_load, imm_done;
    logic                          row_ok, col_ok, sym_ok;
    logic [ROW_W-1:0]              row_a, col_a;
    logic [SYM_W-1:0]              sym_a;
    logic signed [WEIGHT_BITS-1:0] w_sat;

    // units
    t_mac_ctl                mac_ctl;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_idle;
    logic                    tanh_go, tanh_done;
    logic signed [HID_W-1:0] tanh_y;

    assign out_free   = !r_out_v || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign row_ok = int'(i_in_req.row_index) < HIDDEN_UNITS;
    assign col_ok = int'(i_in_req.col_index) < HIDDEN_UNITS;
    assign sym_ok = int'(i_in_req.symbol) < INPUT_SYMBOLS;
    assign row_a  = ROW_W'(i_in_req.row_index);
    assign col_a  = ROW_W'(i_in_req.col_index);
    assign sym_a  = SYM_W'(i_in_req.symbol);
    assign w_sat  = f_sat_weight(i_in_req.weight_value);

    // everything but step and read answers at acceptance
    assign imm_done = in_acc && (i_in_req.op != OP_STEP) && (i_in_req.op != OP_RD_HID);
    assign out_load = imm_done || ((r_state == S_FIN) && out_free);
    assign tanh_go  = (r_state == S_DRAIN) && !r_rd_v && mac_idle;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_req.op == OP_STEP) begin
                    n_state = S_LOAD;
                end else if (in_acc && i_in_req.op == OP_RD_HID) begin
                    n_state = S_FIN;
                end
            end
            S_LOAD:  n_state = S_INIT;
            S_INIT:  n_state = S_MAC;
            S_MAC: begin
                if (r_j == I_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (tanh_go) begin
                    n_state = S_TANH;
                end
            end
            S_TANH: begin
                if (tanh_done) begin
                    n_state = (r_i == I_LAST) ? S_FIN : S_LOAD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_v    <= 1'b0;
            r_hv_valid <= '0;
            r_bank     <= 1'b0;
            r_rd_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= (r_state == S_MAC);
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (in_acc && i_in_req.op == OP_CLR) begin
                r_hv_valid <= '0;
            end else if (tanh_done) begin
                r_hv_valid[{~r_bank, r_i}] <= 1'b1;
            end
            if (tanh_done && r_i == I_LAST) begin
                r_bank <= ~r_bank;   // new hidden vector takes effect
            end
        end
    end

    // request fields and counters
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= i_in_req.op;
            r_sym    <= sym_a;
            r_sym_ok <= sym_ok;
            r_row_ok <= row_ok;
            r_i      <= '0;
        end else if (tanh_done) begin
            r_i <= r_i + 1'b1;
        end
        if (r_state == S_INIT) begin
            r_j <= '0;
        end else if (r_state == S_MAC) begin
            r_j <= r_j + 1'b1;
        end
        if (imm_done) begin
            r_out.hidden_value <= '0;
            r_out.done_op      <= i_in_req.op;
        end else if (r_state == S_FIN && out_free) begin
            r_out.hidden_value <= (r_op == OP_RD_HID && r_row_ok && r_hrd_v) ? r_hrd : '0;
            r_out.done_op      <= r_op;
        end
    end

    // input weights
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_req.op == OP_WR_IN && row_ok && sym_ok) begin
            iw_mem[{row_a, sym_a}] <= w_sat;
        end
        if (r_state == S_LOAD) begin
            r_iw_q <= iw_mem[{r_i, r_sym}];
        end
    end

    // recurrent weights
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_req.op == OP_WR_REC && row_ok && col_ok) begin
            rw_mem[{row_a, col_a}] <= w_sat;
        end
        if (r_state == S_MAC) begin
            r_rw_q <= rw_mem[{r_i, r_j}];
        end
    end

    // biases
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_req.op == OP_WR_BIAS && row_ok) begin
            bias_mem[row_a] <= w_sat;
        end
        if (r_state == S_LOAD) begin
            r_bias_q <= bias_mem[r_i];
        end
    end

    // hidden banks: read current bank, write the other
    always_ff @(posedge i_clk) begin
        if (tanh_done) begin
            hid_mem[{~r_bank, r_i}] <= tanh_y;
        end
        if (r_state == S_MAC) begin
            r_hrd   <= hid_mem[{r_bank, r_j}];
            r_hrd_v <= r_hv_valid[{r_bank, r_j}];
        end else if (in_acc && i_in_req.op == OP_RD_HID) begin
            r_hrd   <= hid_mem[{r_bank, row_a}];
            r_hrd_v <= r_hv_valid[{r_bank, row_a}];
        end
    end

    assign mac_ctl.init  = (r_state == S_INIT);
    assign mac_ctl.valid = r_rd_v;

    rtcs_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_bias  (r_bias_q),
        .i_iw    (r_sym_ok ? r_iw_q : '0),
        .i_w     (r_rw_q),
        .i_h     (r_hrd_v ? r_hrd : '0),
        .o_acc   (mac_acc),
        .o_idle  (mac_idle)
    );

    rtcs_tanh u_tanh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tanh_go),
        .i_acc   (mac_acc),
        .o_done  (tanh_done),
        .o_y     (tanh_y)
    );

    assign o_out_valid = r_out_v;
    assign o_out_rsp   = r_out;

    // MAC read pipeline only runs inside the unit loop
    a_rd_in_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_state == S_MAC || r_state == S_DRAIN))
        else $error("MAC read pipeline active outside unit loop");

    a_tanh_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tanh_done |-> r_state == S_TANH)
        else $error("tanh result outside tanh wait");

    a_bank_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_bank) |-> r_state == S_FIN)
        else $error("hidden bank swapped before step end");

    a_col_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_INIT |=> r_j == '0)
        else $error("column counter not restarted for unit");

endmodule

`default_nettype wire
